FILE: src/bgtm_pkg.sv
package bgtm_pkg;

   localparam int SAMPLES   = 6;
   localparam int MID_COUNT = SAMPLES - 2;
   localparam int UV_W      = 23;
   localparam int PCT_W     = 7;
   localparam int CNT_W     = $clog2(SAMPLES + 1);
   localparam int SUM_W     = UV_W + $clog2(SAMPLES);
   localparam int LEVELS    = 11;

   localparam logic [UV_W-1:0] LEVEL_UV [LEVELS] = '{
      23'd4200000, 23'd4060000, 23'd3980000, 23'd3920000, 23'd3870000, 23'd3820000,
      23'd3790000, 23'd3770000, 23'd3740000, 23'd3680000, 23'd3450000
   };
   localparam logic [PCT_W-1:0] LEVEL_PCT [LEVELS] = '{
      7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd5
   };

   localparam logic [PCT_W-1:0] PCT_LOW      = 7'd10;
   localparam logic [PCT_W-1:0] PCT_SHUTDOWN = 7'd5;

   localparam logic [UV_W-1:0] VALID_LOW_RST  = 23'd3300000;
   localparam logic [UV_W-1:0] VALID_HIGH_RST = 23'd4400000;

   typedef enum logic {
      CSR_VALID_LOW  = 1'b0,
      CSR_VALID_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ALARM_NONE      = 3'd0,
      ALARM_LOW       = 3'd1,
      ALARM_SHUTDOWN  = 3'd2,
      ALARM_CHG_START = 3'd3,
      ALARM_STOP      = 3'd4
   } alarm_type;

   typedef enum logic [2:0] {
      LED_KEEP       = 3'd0,
      LED_RED_SOLID  = 3'd1,
      LED_BLUE_SOLID = 3'd2,
      LED_RED_BLINK  = 3'd3,
      LED_OFF        = 3'd4
   } led_type;

   // first threshold that the voltage reaches wins; below all of them is empty
   function automatic logic [PCT_W-1:0] percent_of(input logic [UV_W-1:0] uv);
      logic [PCT_W-1:0] pct;
      pct = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (uv >= LEVEL_UV[i]) pct = LEVEL_PCT[i];
      end
      return pct;
   endfunction

endpackage

FILE: src/battery_gauge_trimmed_mean.sv
// channel | ports                                        | direction
// req     | req_valid / req_stall, sample and pin fields | in
// rsp     | rsp_valid / rsp_stall, level, alarm, led     | out
// csr     | csr_wr_en, csr_index, csr_wdata              | in
//
// one transaction per cycle sustained while rsp is not stalled; req reaches rsp through
// the input register, then the result register
// trimmed mean is running sum minus running min and max, over four, so the sixth kept
// sample finishes in the same single pass
// reset is synchronous and active high
// a stalled rsp holds the input register; req_stall rises only when both are full
module battery_gauge_trimmed_mean
   import bgtm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [UV_W-1:0]   req_sample_uv,
   input  logic              req_charger_connected,
   input  logic              req_charging_pin,
   input  logic              req_full_pin,
   input  logic              req_alarm_idle,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_level_updated,
   output logic [UV_W-1:0]   rsp_filtered_uv,
   output logic [PCT_W-1:0]  rsp_battery_percent,
   output logic [2:0]        rsp_alarm_raise,
   output logic [2:0]        rsp_led_command,
   output logic              rsp_charge_active,

   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [UV_W-1:0]   csr_wdata
);

   // configuration
   logic [UV_W-1:0]  valid_low_ff, valid_high_ff;

   // input register
   logic             in_valid_ff;
   logic [UV_W-1:0]  in_sample_ff;
   logic             in_conn_ff, in_chg_ff, in_full_ff, in_idle_ff;

   // gauge state
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [UV_W-1:0]  run_min_ff, run_min_in;
   logic [UV_W-1:0]  run_max_ff, run_max_in;
   logic [PCT_W-1:0] level_ff, level_in;
   logic [UV_W-1:0]  mean_ff, mean_in;
   logic             seen_ff, seen_in;

   // result register
   logic             rsp_valid_ff;
   logic             upd_ff, upd_in;
   alarm_type        alarm_ff, alarm_in;
   led_type          led_ff, led_in;
   logic             conn_out_ff;

   logic             advance;
   logic             keep;
   logic             done;
   logic             first;
   logic [SUM_W-1:0] mid_sum;
   logic             pending;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_low_ff  <= VALID_LOW_RST;
         valid_high_ff <= VALID_HIGH_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_VALID_LOW:  valid_low_ff  <= csr_wdata;
            CSR_VALID_HIGH: valid_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_sample_ff <= req_sample_uv;
         in_conn_ff   <= req_charger_connected;
         in_chg_ff    <= req_charging_pin;
         in_full_ff   <= req_full_pin;
         in_idle_ff   <= req_alarm_idle;
      end
   end

   always_comb begin
      keep  = (in_sample_ff > valid_low_ff) && (in_sample_ff < valid_high_ff);
      first = (cnt_ff == '0);
      done  = keep && (cnt_ff == CNT_W'(SAMPLES - 1));

      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      if (keep) begin
         cnt_in     = cnt_ff + CNT_W'(1);
         sum_in     = first ? SUM_W'(in_sample_ff) : sum_ff + SUM_W'(in_sample_ff);
         run_min_in = (first || in_sample_ff < run_min_ff) ? in_sample_ff : run_min_ff;
         run_max_in = (first || in_sample_ff > run_max_ff) ? in_sample_ff : run_max_ff;
      end

      // middle entries of the sorted set sum to the total less its extremes
      mid_sum  = sum_in - SUM_W'(run_min_in) - SUM_W'(run_max_in);
      mean_in  = mean_ff;
      level_in = level_ff;
      upd_in   = 1'b0;
      alarm_in = ALARM_NONE;
      pending  = !in_idle_ff;
      if (done) begin
         cnt_in   = '0;
         upd_in   = 1'b1;
         mean_in  = UV_W'(mid_sum / MID_COUNT);
         level_in = percent_of(mean_in);
         if (!pending && level_in == PCT_LOW) begin
            alarm_in = ALARM_LOW;
            pending  = 1'b1;
         end else if (!pending && level_in == PCT_SHUTDOWN) begin
            alarm_in = ALARM_SHUTDOWN;
            pending  = 1'b1;
         end
      end

      seen_in = seen_ff;
      if (in_conn_ff) begin
         if (!seen_ff && !pending) begin
            alarm_in = ALARM_CHG_START;
            seen_in  = 1'b1;
         end
         if (in_chg_ff && !in_full_ff)      led_in = LED_RED_SOLID;
         else if (!in_chg_ff && in_full_ff) led_in = LED_BLUE_SOLID;
         else                               led_in = LED_KEEP;
      end else begin
         if (seen_ff && !pending) begin
            alarm_in = ALARM_STOP;
            seen_in  = 1'b0;
         end
         led_in = (level_in <= PCT_LOW) ? LED_RED_BLINK : LED_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         level_ff <= '0;
         mean_ff  <= '0;
         seen_ff  <= 1'b0;
      end else if (advance) begin
         cnt_ff   <= cnt_in;
         level_ff <= level_in;
         mean_ff  <= mean_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff     <= sum_in;
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         upd_ff      <= upd_in;
         alarm_ff    <= alarm_in;
         led_ff      <= led_in;
         conn_out_ff <= in_conn_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_level_updated   = upd_ff;
   assign rsp_filtered_uv     = mean_ff;
   assign rsp_battery_percent = level_ff;
   assign rsp_alarm_raise     = alarm_ff;
   assign rsp_led_command     = led_ff;
   assign rsp_charge_active   = conn_out_ff;

   a_done_updates: assert property (@(posedge clock) disable iff (reset)
      advance && done |=> rsp_valid_ff && upd_ff && cnt_ff == '0)
      else $error("completed sample set did not produce an update");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed transaction lost before the result register");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> run_min_ff <= run_max_ff)
      else $error("running minimum above running maximum");

   a_level_alarm_on_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (alarm_ff == ALARM_LOW || alarm_ff == ALARM_SHUTDOWN) |-> upd_ff)
      else $error("level alarm raised without a level update");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      advance && !keep |=> cnt_ff == $past(cnt_ff))
      else $error("kept count moved on a dropped sample");

endmodule

FILE: verif/battery_gauge_trimmed_mean_tb.sv
`timescale 1ns / 100ps

module battery_gauge_trimmed_mean_tb;
   import bgtm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int UV_MAX      = (1 << UV_W) - 1;

   typedef struct packed {
      logic              updated;
      logic [UV_W-1:0]   filtered_uv;
      logic [PCT_W-1:0]  percent;
      alarm_type         alarm;
      led_type           led;
      logic              charge_active;
   } gauge_result_type;

   logic              clock;
   logic              reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [UV_W-1:0]   req_sample_uv = '0;
   logic              req_charger_connected = 1'b0;
   logic              req_charging_pin = 1'b0;
   logic              req_full_pin = 1'b0;
   logic              req_alarm_idle = 1'b0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_level_updated;
   logic [UV_W-1:0]   rsp_filtered_uv;
   logic [PCT_W-1:0]  rsp_battery_percent;
   logic [2:0]        rsp_alarm_raise;
   logic [2:0]        rsp_led_command;
   logic              rsp_charge_active;

   logic              csr_wr_en = 1'b0;
   logic              csr_index = 1'b0;
   logic [UV_W-1:0]   csr_wdata = '0;

   // gauge model state
   logic [UV_W-1:0]   window_low = 23'd3300000;
   logic [UV_W-1:0]   window_high = 23'd4400000;
   logic [UV_W-1:0]   kept_uv [SAMPLES];
   int                kept_n = 0;
   int                level_pct = 0;
   logic [UV_W-1:0]   mean_uv = '0;
   logic              charger_seen = 1'b0;

   gauge_result_type  expected_q [$];
   int                errors = 0;
   int                cycle_count = 0;
   int                hold_until = 0;
   int                send_idle_pct = 32;
   int                stall_pct = 54;

   battery_gauge_trimmed_mean DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d transactions outstanding", $time, expected_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: long hold-off when requested, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (cycle_count < hold_until) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic int threshold_uv(input int k);
      case (k)
         0: return 4200000;
         1: return 4060000;
         2: return 3980000;
         3: return 3920000;
         4: return 3870000;
         5: return 3820000;
         6: return 3790000;
         7: return 3770000;
         8: return 3740000;
         9: return 3680000;
         default: return 3450000;
      endcase
   endfunction

   function automatic int percent_for_uv(input logic [UV_W-1:0] uv);
      for (int k = 0; k < 11; k++) begin
         if (uv >= threshold_uv(k)) begin
            if (k == 10) return 5;
            return 100 - 10 * k;
         end
      end
      return 0;
   endfunction

   task automatic predict_gauge(input logic [UV_W-1:0] uv, input logic conn, input logic chg,
                                input logic full, input logic idle);
      gauge_result_type res;
      logic          pending;
      int unsigned   total;
      int unsigned   lo;
      int unsigned   hi;
      res = '0;
      res.alarm = ALARM_NONE;
      res.led = LED_KEEP;
      pending = !idle;
      if (uv > window_low && uv < window_high) begin
         if (kept_n < SAMPLES) kept_uv[kept_n] = uv;
         kept_n++;
      end
      if (kept_n >= SAMPLES) begin
         kept_n = 0;
         res.updated = 1'b1;
         total = 0;
         lo = UV_MAX;
         hi = 0;
         // trimmed sum: everything minus one smallest and one largest
         foreach (kept_uv[i]) begin
            total += 32'(kept_uv[i]);
            if (kept_uv[i] < lo) lo = 32'(kept_uv[i]);
            if (kept_uv[i] > hi) hi = 32'(kept_uv[i]);
         end
         mean_uv = UV_W'((total - lo - hi) / (SAMPLES - 2));
         level_pct = percent_for_uv(mean_uv);
         if (!pending && level_pct == 10) begin
            res.alarm = ALARM_LOW;
            pending = 1'b1;
         end else if (!pending && level_pct == 5) begin
            res.alarm = ALARM_SHUTDOWN;
            pending = 1'b1;
         end
      end
      if (conn) begin
         if (!charger_seen && !pending) begin
            res.alarm = ALARM_CHG_START;
            charger_seen = 1'b1;
         end
         if (chg && !full) res.led = LED_RED_SOLID;
         else if (!chg && full) res.led = LED_BLUE_SOLID;
      end else begin
         if (charger_seen && !pending) begin
            res.alarm = ALARM_STOP;
            charger_seen = 1'b0;
         end
         if (level_pct <= 10) res.led = LED_RED_BLINK;
         else res.led = LED_OFF;
      end
      res.filtered_uv = mean_uv;
      res.percent = PCT_W'(level_pct);
      res.charge_active = conn;
      expected_q.push_back(res);
   endtask

   task automatic send_sample(input logic [UV_W-1:0] uv, input logic conn, input logic chg,
                              input logic full, input logic idle);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_uv <= uv;
      req_charger_connected <= conn;
      req_charging_pin <= chg;
      req_full_pin <= full;
      req_alarm_idle <= idle;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_gauge(uv, conn, chg, full, idle);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_window(input logic [UV_W-1:0] lo, input logic [UV_W-1:0] hi);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_VALID_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_VALID_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      window_low = lo;
      window_high = hi;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      gauge_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transaction, got uv %0d pct %0d alarm %0d led %0d",
                     $time, rsp_filtered_uv, rsp_battery_percent, rsp_alarm_raise,
                     rsp_led_command);
            errors++;
         end else begin
            want = expected_q.pop_front();
            check_field("level_updated", 32'(want.updated), 32'(rsp_level_updated));
            check_field("filtered_uv", 32'(want.filtered_uv), 32'(rsp_filtered_uv));
            check_field("battery_percent", 32'(want.percent), 32'(rsp_battery_percent));
            check_field("alarm_raise", 32'(want.alarm), 32'(rsp_alarm_raise));
            check_field("led_command", 32'(want.led), 32'(rsp_led_command));
            check_field("charge_active", 32'(want.charge_active), 32'(rsp_charge_active));
         end
      end
   end

   // well-formed sets around a drifting voltage, some out-of-window noise,
   // rare charger edges and mostly idle alarm state
   task automatic run_traffic(input int count);
      int   center;
      int   uv;
      logic conn;
      conn = 1'b0;
      center = 3800000;
      for (int i = 0; i < count; i++) begin
         if (i % 6 == 0) begin
            if ($urandom_range(99) < 60) begin
               center = threshold_uv(int'($urandom_range(10))) + int'($urandom_range(30000))
                        - 15000;
            end else if (window_high > window_low) begin
               center = int'($urandom_range(window_high, window_low));
            end
         end
         if ($urandom_range(99) < 15 || window_high <= window_low + 1) begin
            uv = int'($urandom_range(UV_MAX));
         end else begin
            uv = center + int'($urandom_range(40000)) - 20000;
            if (uv <= int'(window_low)) uv = window_low + 1;
            if (uv >= int'(window_high)) uv = window_high - 1;
         end
         if ($urandom_range(99) < 8) conn = !conn;
         send_sample(UV_W'(uv), conn, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     $urandom_range(99) < 80);
      end
   endtask

   task automatic test_directed_cases();
      send_sample(23'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      // pending alarm blocks the charging alarm
      send_sample(UV_W'(UV_MAX), 1'b1, 1'b1, 1'b1, 1'b0);
      // window bounds are exclusive
      send_sample(23'd3300000, 1'b0, 1'b0, 1'b0, 1'b1);
      send_sample(23'd4400000, 1'b0, 1'b1, 1'b0, 1'b1);
      send_sample(23'd3300001, 1'b0, 1'b0, 1'b0, 1'b1);
      send_sample(23'd4399999, 1'b0, 1'b0, 1'b0, 1'b1);
      repeat (3) send_sample(23'd3690000, 1'b0, 1'b0, 1'b0, 1'b1);
      // low battery alarm hides the connect edge in the same transaction
      send_sample(23'd3690000, 1'b1, 1'b1, 1'b0, 1'b1);
      send_sample(23'd0, 1'b1, 1'b0, 1'b1, 1'b0);
      send_sample(23'd0, 1'b1, 1'b0, 1'b1, 1'b1);
      send_sample(23'd0, 1'b1, 1'b1, 1'b1, 1'b1);
      repeat (5) send_sample(23'd3460000, 1'b1, 1'b1, 1'b0, 1'b1);
      // shutdown alarm hides the disconnect edge
      send_sample(23'd3460000, 1'b0, 1'b0, 1'b0, 1'b1);
      send_sample(23'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      repeat (6) send_sample(23'd4300000, 1'b0, 1'b1, 1'b1, 1'b1);
      wait_for_results();
   endtask

   task automatic test_window_extremes();
      set_window(23'd0, UV_W'(UV_MAX));
      repeat (40) begin
         send_sample(UV_W'($urandom_range(UV_MAX)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      wait_for_results();
      // inverted window keeps nothing
      set_window(UV_W'(UV_MAX), 23'd0);
      repeat (8) begin
         send_sample(UV_W'($urandom_range(UV_MAX)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      wait_for_results();
      set_window(23'd3900000, 23'd3900000);
      repeat (6) send_sample(23'd3900000, 1'b0, 1'b0, 1'b0, 1'b1);
      wait_for_results();
      set_window(23'd0, 23'd2);
      repeat (6) send_sample(23'd1, 1'b0, 1'b0, 1'b0, 1'b1);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      set_window(23'd3300000, 23'd4400000);
      send_idle_pct = 0;
      hold_until = cycle_count + 150;
      run_traffic(40);
      wait_for_results();
      send_idle_pct = 32;
   endtask

   task automatic test_random_traffic();
      send_idle_pct = 32;
      stall_pct = 54;
      set_window(23'd3300000, 23'd4400000);
      run_traffic(190);
      wait_for_results();
      send_idle_pct = 54;
      stall_pct = 32;
      set_window(UV_W'($urandom_range(3450000, 3000000)),
                 UV_W'($urandom_range(4600000, 4150000)));
      run_traffic(190);
      wait_for_results();
      send_idle_pct = 0;
      stall_pct = 0;
      set_window(23'd3400000, 23'd4300000);
      run_traffic(200);
      wait_for_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_window_extremes();
      test_backpressure();
      test_random_traffic();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/bgtm_pkg.sv
src/battery_gauge_trimmed_mean.sv
verif/battery_gauge_trimmed_mean_tb.sv
